/* design/prseg_pkg.sv */
// Package for the color-tolerant pixel run segmenter.
// Holds the field widths, register codes, metric codes, arithmetic constants and the
// controller/datapath interface types. It depends on nothing.
`default_nettype none

package prseg_pkg;

  localparam int ROW_PIX_MAX = 4096;
  localparam int MAX_ROWS   = 4096;

  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int CLR_W      = 8;
  localparam int METRIC_W   = 2;
  localparam int THR_W      = 15;
  localparam int RWID_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int ROW_CAP_I  = (MAX_ROWS - 1 > 4095) ? 4095 : MAX_ROWS - 1;
  localparam logic [ROW_W-1:0]  ROW_CAP     = ROW_W'(ROW_CAP_I);
  localparam logic [COL_W-1:0]  LAST_COL_MAX = COL_W'(ROW_PIX_MAX - 1);
  localparam logic [RWID_W-1:0] WIDTH_LIMIT  = RWID_W'(ROW_PIX_MAX);

  localparam logic [THR_W-1:0]  THR_RESET    = 15'd20480;
  localparam logic [RWID_W-1:0] RWID_RESET   = 13'd4096;

  // Full scale of the similarity in units of 1/256 percent.
  localparam logic [THR_W-1:0]  FULL_PCT     = 15'd25600;
  localparam logic [29:0]       FULL_PCT_SQ  = 30'd655360000;
  localparam logic [17:0]       EUC_MAX2     = 18'd195075;
  localparam logic [9:0]        MAN_MAX      = 10'd765;
  localparam logic [9:0]        COS_SCALE    = 10'd625;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METRIC    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_ROW_WIDTH = 2'd2
  } cfg_idx_t;

  typedef enum logic [METRIC_W-1:0] {
    METRIC_EUCLID    = 2'd0,
    METRIC_MANHATTAN = 2'd1,
    METRIC_COSINE    = 2'd2,
    METRIC_NONE      = 2'd3
  } metric_t;

  typedef struct packed {
    logic load;
    logic commit;
  } prseg_cmd_t;

  typedef struct packed {
    logic out_empty;
  } prseg_sts_t;

  typedef struct packed {
    logic [COL_W-1:0] start_col;
    logic [COL_W-1:0] end_col;
    logic [ROW_W-1:0] row;
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
    logic             last;
  } seg_word_t;

endpackage

`default_nettype wire

/* design/pixel_run_segmenter_by_color_similarity.sv */
// Top level of the color-tolerant pixel run segmenter.
// Instantiates prseg_ctrl and prseg_dp; depends on prseg_pkg.
`default_nettype none

// Takes BGR pixels in raster order and emits color runs as words of start column,
// end column, row and the color of the run's first pixel. Each pixel yields zero,
// one or two words; the last word of a pixel carries out_last. An accepted pixel
// is captured, goes through the three multiplier stages of the similarity test
// (products, squares, the split wide cosine product) and then reaches the wide
// compare and the run update. The decision waits while words of the previous
// pixel remain in the two-word output buffer. The user must write configuration
// via cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
module pixel_run_segmenter_by_color_similarity (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [prseg_pkg::CLR_W-1:0]       in_pixel_blue,
  input  wire logic [prseg_pkg::CLR_W-1:0]       in_pixel_green,
  input  wire logic [prseg_pkg::CLR_W-1:0]       in_pixel_red,
  input  wire logic                              in_frame_start,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [prseg_pkg::COL_W-1:0]            out_seg_start_col,
  output logic [prseg_pkg::COL_W-1:0]            out_seg_end_col,
  output logic [prseg_pkg::ROW_W-1:0]            out_seg_row,
  output logic [prseg_pkg::CLR_W-1:0]            out_seg_red,
  output logic [prseg_pkg::CLR_W-1:0]            out_seg_green,
  output logic [prseg_pkg::CLR_W-1:0]            out_seg_blue,
  output logic                                   out_last,
  input  wire logic                              cfg_we,
  input  wire logic [prseg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [prseg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import prseg_pkg::*;

  prseg_cmd_t cmd;
  prseg_sts_t sts;

  prseg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prseg_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_pixel_blue     (in_pixel_blue),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_red      (in_pixel_red),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_seg_start_col (out_seg_start_col),
    .out_seg_end_col   (out_seg_end_col),
    .out_seg_row       (out_seg_row),
    .out_seg_red       (out_seg_red),
    .out_seg_green     (out_seg_green),
    .out_seg_blue      (out_seg_blue),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

/* design/prseg_ctrl.sv */
// Controller state machine of the pixel run segmenter.
// Sequences one pixel through the datapath stages; depends on prseg_pkg.
`default_nettype none

module prseg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire prseg_pkg::prseg_sts_t sts,
  output prseg_pkg::prseg_cmd_t   cmd
);
  import prseg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PROD   = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_WIDE   = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_WIDE;
      end
      ST_WIDE: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.out_empty) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/prseg_dp.sv */
// Datapath of the pixel run segmenter: configuration registers, run state,
// the staged similarity arithmetic and the two-word result buffer.
// Depends on prseg_pkg.
`default_nettype none

module prseg_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire prseg_pkg::prseg_cmd_t                 cmd,
  output prseg_pkg::prseg_sts_t                      sts,
  input  wire logic                                  cfg_we,
  input  wire logic [prseg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [prseg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [prseg_pkg::CLR_W-1:0]           in_pixel_blue,
  input  wire logic [prseg_pkg::CLR_W-1:0]           in_pixel_green,
  input  wire logic [prseg_pkg::CLR_W-1:0]           in_pixel_red,
  input  wire logic                                  in_frame_start,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [prseg_pkg::COL_W-1:0]                out_seg_start_col,
  output logic [prseg_pkg::COL_W-1:0]                out_seg_end_col,
  output logic [prseg_pkg::ROW_W-1:0]                out_seg_row,
  output logic [prseg_pkg::CLR_W-1:0]                out_seg_red,
  output logic [prseg_pkg::CLR_W-1:0]                out_seg_green,
  output logic [prseg_pkg::CLR_W-1:0]                out_seg_blue,
  output logic                                       out_last
);
  import prseg_pkg::*;

  function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, a} * {8'd0, b};
    return p;
  endfunction

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

  // Configuration.
  metric_t             metric_r;
  logic [THR_W-1:0]    thr_r;
  logic [RWID_W-1:0]   row_width_r;

  // Run state.
  logic [COL_W-1:0]    run_start_r;
  logic [3*CLR_W-1:0]  run_color_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;

  // Accepted pixel.
  logic [CLR_W-1:0]    pb_r;
  logic [CLR_W-1:0]    pg_r;
  logic [CLR_W-1:0]    pr_r;
  logic                frame_r;

  // First stage: channel products and squared thresholds.
  logic [17:0]         d2_r;
  logic [9:0]          man_r;
  logic [17:0]         dot_r;
  logic [17:0]         n1_r;
  logic [17:0]         n2_r;
  logic [THR_W-1:0]    k_r;
  logic [29:0]         k2_r;
  logic [29:0]         t2_r;

  // Second stage.
  logic [47:0]         euc_l_r;
  logic [47:0]         euc_r_r;
  logic                man_split_r;
  logic [35:0]         dot2_r;
  logic [35:0]         nn_r;

  // Third stage.
  logic                euc_split_r;
  logic [45:0]         dot625_r;
  logic [47:0]         p_hi_r;
  logic [47:0]         p_lo_r;
  logic                nn_nz_r;

  // Result buffer.
  seg_word_t           slot0_r;
  seg_word_t           slot1_r;
  logic [1:0]          cnt_r;

  logic [CLR_W-1:0]    rb;
  logic [CLR_W-1:0]    rg;
  logic [CLR_W-1:0]    rr;
  logic [CLR_W-1:0]    db;
  logic [CLR_W-1:0]    dg;
  logic [CLR_W-1:0]    dr;
  logic [24:0]         man_l;
  logic [24:0]         man_rhs;
  logic [66:0]         cos_rhs;
  logic [66:0]         cos_lhs;
  logic                cos_split;
  logic                split;
  logic [COL_W-1:0]    col_cur;
  logic [ROW_W-1:0]    row_cur;
  logic [RWID_W-1:0]   rw_m1;
  logic [COL_W-1:0]    last_col;
  logic                split_hit;
  logic                row_end;
  logic [COL_W-1:0]    start_nxt;
  logic [3*CLR_W-1:0]  color_nxt;
  logic [3*CLR_W-1:0]  pix;
  seg_word_t           word_a;
  seg_word_t           word_b;

  assign rb  = run_color_r[CLR_W-1:0];
  assign rg  = run_color_r[2*CLR_W-1:CLR_W];
  assign rr  = run_color_r[3*CLR_W-1:2*CLR_W];
  assign db  = absdiff8(rb, pb_r);
  assign dg  = absdiff8(rg, pg_r);
  assign dr  = absdiff8(rr, pr_r);
  assign pix = {pr_r, pg_r, pb_r};

  always_ff @(posedge clk) begin
    d2_r   <= 18'(mul8(db, db)) + 18'(mul8(dg, dg)) + 18'(mul8(dr, dr));
    man_r  <= 10'(db) + 10'(dg) + 10'(dr);
    dot_r  <= 18'(mul8(rb, pb_r)) + 18'(mul8(rg, pg_r)) + 18'(mul8(rr, pr_r));
    n1_r   <= 18'(mul8(rb, rb)) + 18'(mul8(rg, rg)) + 18'(mul8(rr, rr));
    n2_r   <= 18'(mul8(pb_r, pb_r)) + 18'(mul8(pg_r, pg_r)) + 18'(mul8(pr_r, pr_r));
    k_r    <= FULL_PCT - thr_r;
    k2_r   <= 30'(k_r) * 30'(k_r);
    t2_r   <= 30'(thr_r) * 30'(thr_r);
  end

  assign man_l   = 25'(man_r) * 25'(FULL_PCT);
  assign man_rhs = 25'(k_r) * 25'(MAN_MAX);

  always_ff @(posedge clk) begin
    euc_l_r     <= 48'(d2_r) * 48'(FULL_PCT_SQ);
    euc_r_r     <= 48'(k2_r) * 48'(EUC_MAX2);
    man_split_r <= man_l > man_rhs;
    dot2_r      <= 36'(dot_r) * 36'(dot_r);
    nn_r        <= 36'(n1_r) * 36'(n2_r);
  end

  always_ff @(posedge clk) begin
    euc_split_r <= euc_l_r > euc_r_r;
    dot625_r    <= 46'(dot2_r) * 46'(COS_SCALE);
    p_hi_r      <= 48'(t2_r) * 48'(nn_r[35:18]);
    p_lo_r      <= 48'(t2_r) * 48'(nn_r[17:0]);
    nn_nz_r     <= (nn_r != 36'd0);
  end

  assign cos_rhs   = 67'({p_hi_r, 18'd0}) + 67'(p_lo_r);
  assign cos_lhs   = 67'({dot625_r, 20'd0});
  assign cos_split = cos_lhs < cos_rhs;

  always_comb begin
    if (thr_r == '0) begin
      split = 1'b0;
    end else if (thr_r > FULL_PCT) begin
      split = 1'b1;
    end else begin
      case (metric_r)
        METRIC_EUCLID:    split = euc_split_r;
        METRIC_MANHATTAN: split = man_split_r;
        METRIC_COSINE:    split = !nn_nz_r || cos_split;
        default:          split = 1'b1;
      endcase
    end
  end

  assign rw_m1 = row_width_r - RWID_W'(1);

  always_comb begin
    if (row_width_r == '0) begin
      last_col = '0;
    end else if (row_width_r > WIDTH_LIMIT) begin
      last_col = LAST_COL_MAX;
    end else begin
      last_col = rw_m1[COL_W-1:0];
    end
  end

  assign col_cur   = frame_r ? '0 : col_r;
  assign row_cur   = frame_r ? '0 : row_r;
  assign split_hit = (col_cur != '0) && split;
  assign row_end   = (col_cur >= last_col);
  assign start_nxt = (col_cur == '0) ? '0 : (split_hit ? col_cur : run_start_r);
  assign color_nxt = ((col_cur == '0) || split_hit) ? pix : run_color_r;

  always_comb begin
    word_a.start_col = run_start_r;
    word_a.end_col   = col_cur - COL_W'(1);
    word_a.row       = row_cur;
    word_a.red       = rr;
    word_a.green     = rg;
    word_a.blue      = rb;
    word_a.last      = !row_end;
    word_b.start_col = start_nxt;
    word_b.end_col   = col_cur;
    word_b.row       = row_cur;
    word_b.red       = color_nxt[3*CLR_W-1:2*CLR_W];
    word_b.green     = color_nxt[2*CLR_W-1:CLR_W];
    word_b.blue      = color_nxt[CLR_W-1:0];
    word_b.last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pb_r    <= in_pixel_blue;
      pg_r    <= in_pixel_green;
      pr_r    <= in_pixel_red;
      frame_r <= in_frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r    <= METRIC_EUCLID;
      thr_r       <= THR_RESET;
      row_width_r <= RWID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METRIC:    metric_r    <= metric_t'(cfg_data[METRIC_W-1:0]);
        CFG_THRESHOLD: thr_r       <= cfg_data[THR_W-1:0];
        CFG_ROW_WIDTH: row_width_r <= cfg_data[RWID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_start_r <= '0;
      run_color_r <= '0;
      col_r       <= '0;
      row_r       <= '0;
    end else if (cmd.commit) begin
      run_start_r <= start_nxt;
      run_color_r <= color_nxt;
      if (row_end) begin
        col_r <= '0;
        row_r <= (row_cur < ROW_CAP) ? row_cur + ROW_W'(1) : row_cur;
      end else begin
        col_r <= col_cur + COL_W'(1);
        row_r <= row_cur;
      end
    end
  end

  // The buffer is only loaded when empty, so a load and a pop never meet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (cmd.commit) begin
      cnt_r <= 2'(split_hit) + 2'(row_end);
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot0_r <= split_hit ? word_a : word_b;
      slot1_r <= word_b;
    end else if (out_valid && out_ready) begin
      slot0_r <= slot1_r;
    end
  end

  assign sts.out_empty     = (cnt_r == 2'd0);
  assign out_valid         = (cnt_r != 2'd0);
  assign out_seg_start_col = slot0_r.start_col;
  assign out_seg_end_col   = slot0_r.end_col;
  assign out_seg_row       = slot0_r.row;
  assign out_seg_red       = slot0_r.red;
  assign out_seg_green     = slot0_r.green;
  assign out_seg_blue      = slot0_r.blue;
  assign out_last          = slot0_r.last;

endmodule

`default_nettype wire

/* tb/prseg_run_checker.sv */
// Run checker for the color-tolerant pixel run segmenter: follows the register writes, predicts
// the run words that each accepted pixel closes and compares them with the words the block emits.
// Depends on prseg_pkg for the register and metric codes and the run word layout.
module prseg_run_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire logic [prseg_pkg::CLR_W-1:0]      in_blue,
  input  wire logic [prseg_pkg::CLR_W-1:0]      in_green,
  input  wire logic [prseg_pkg::CLR_W-1:0]      in_red,
  input  wire logic                             in_frame_start,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic [prseg_pkg::COL_W-1:0]      out_start_col,
  input  wire logic [prseg_pkg::COL_W-1:0]      out_end_col,
  input  wire logic [prseg_pkg::ROW_W-1:0]      out_row,
  input  wire logic [prseg_pkg::CLR_W-1:0]      out_red,
  input  wire logic [prseg_pkg::CLR_W-1:0]      out_green,
  input  wire logic [prseg_pkg::CLR_W-1:0]      out_blue,
  input  wire logic                             out_last,
  input  wire logic                             cfg_we,
  input  wire logic [prseg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prseg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             flush,
  output int                                    fail_count,
  output int                                    words_due
);
  import prseg_pkg::*;

  localparam logic [63:0] PCT_FULL  = 64'd25600;
  localparam logic [63:0] EUC_PEAK  = 64'd195075;
  localparam logic [63:0] MAN_PEAK  = 64'd765;
  localparam logic [11:0] ROW_TOP   = 12'((MAX_ROWS - 1 > 4095) ? 4095 : MAX_ROWS - 1);

  metric_t     metric_sel = METRIC_EUCLID;
  logic [14:0] thr_q8     = 15'd20480;
  logic [12:0] row_width  = 13'd4096;
  logic [11:0] run_col0   = '0;
  logic [23:0] run_rgb    = '0;
  logic [11:0] col_pos    = '0;
  logic [11:0] row_pos    = '0;
  seg_word_t   runs_due[$];
  bit          flushed    = 1'b0;
  int          words_seen = 0;

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  task automatic report(input string msg);
    fail_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("word %0d %s: got %0d, expected %0d", words_seen, name, got, want));
    end
  endtask

  function automatic bit similarity_too_low(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r);
    logic [63:0]  cb, cg, cr, db, dg, dr, k, dot, n1, n2;
    logic [127:0] lhs, rhs;
    cb = run_rgb[7:0];
    cg = run_rgb[15:8];
    cr = run_rgb[23:16];
    if (thr_q8 == 0) return 1'b0;
    if (thr_q8 > PCT_FULL) return 1'b1;
    k  = PCT_FULL - thr_q8;
    db = (cb > b) ? cb - b : b - cb;
    dg = (cg > g) ? cg - g : g - cg;
    dr = (cr > r) ? cr - r : r - cr;
    case (metric_sel)
      METRIC_EUCLID: begin
        dot = db * db + dg * dg + dr * dr;
        return PCT_FULL * PCT_FULL * dot > k * k * EUC_PEAK;
      end
      METRIC_MANHATTAN: begin
        return PCT_FULL * (db + dg + dr) > k * MAN_PEAK;
      end
      METRIC_COSINE: begin
        dot = cb * b + cg * g + cr * r;
        n1  = cb * cb + cg * cg + cr * cr;
        n2  = b * b + g * g + r * r;
        if (n1 == 0 || n2 == 0) return 1'b1;
        lhs = 128'(dot) * 128'(dot) * 128'd625 * (128'd1 << 20);
        rhs = 128'(thr_q8) * 128'(thr_q8) * 128'(n1) * 128'(n2);
        return lhs < rhs;
      end
      default: begin
        return 1'b1;
      end
    endcase
  endfunction

  function automatic seg_word_t close_run(input logic [11:0] end_col);
    seg_word_t w;
    w.start_col = run_col0;
    w.end_col   = end_col;
    w.row       = row_pos;
    w.red       = run_rgb[23:16];
    w.green     = run_rgb[15:8];
    w.blue      = run_rgb[7:0];
    w.last      = 1'b0;
    return w;
  endfunction

  task automatic predict_runs(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                              input logic fs);
    seg_word_t fresh[$];
    int        span;
    span = (row_width == 0) ? 1 :
           ((row_width > ROW_PIX_MAX) ? ROW_PIX_MAX : int'(row_width));
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    if (col_pos == 0) begin
      run_col0 = '0;
      run_rgb  = {r, g, b};
    end else if (similarity_too_low(b, g, r)) begin
      fresh    = {fresh, close_run(col_pos - 12'd1)};
      run_col0 = col_pos;
      run_rgb  = {r, g, b};
    end
    if (int'(col_pos) >= span - 1) begin
      fresh   = {fresh, close_run(col_pos)};
      col_pos = '0;
      if (row_pos < ROW_TOP) row_pos++;
    end else begin
      col_pos++;
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    runs_due = {runs_due, fresh};
  endtask

  always @(posedge clk) begin : watch
    seg_word_t want;
    if (!rst_n) begin
      metric_sel = METRIC_EUCLID;
      thr_q8     = 15'd20480;
      row_width  = 13'd4096;
      run_col0   = '0;
      run_rgb    = '0;
      col_pos    = '0;
      row_pos    = '0;
      runs_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_METRIC:    metric_sel = metric_t'(cfg_data[1:0]);
          CFG_THRESHOLD: thr_q8     = cfg_data[14:0];
          CFG_ROW_WIDTH: row_width  = cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_runs(in_blue, in_green, in_red, in_frame_start);
      end
      if (out_valid && out_ready) begin
        if (runs_due.size() == 0) begin
          report($sformatf("word %0d arrived with no run expected", words_seen));
        end else begin
          want = runs_due.pop_front();
          check_field("start_col", out_start_col, want.start_col);
          check_field("end_col", out_end_col, want.end_col);
          check_field("row", out_row, want.row);
          check_field("red", out_red, want.red);
          check_field("green", out_green, want.green);
          check_field("blue", out_blue, want.blue);
          check_field("last", out_last, want.last);
        end
        words_seen++;
      end
      if (flush && !flushed) begin
        foreach (runs_due[i]) begin
          report($sformatf("run %0d..%0d of row %0d never arrived", runs_due[i].start_col,
                           runs_due[i].end_col, runs_due[i].row));
        end
        runs_due.delete();
        flushed = 1'b1;
      end
    end
    words_due <= runs_due.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the pixel run segmenter testbench: clock, reset, register writes and pixel stimulus
// with random idling on both channels. Depends on prseg_pkg, the segmenter and prseg_run_checker.
module tb_top;
  import prseg_pkg::*;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic [CLR_W-1:0]      in_pixel_blue  = '0;
  logic [CLR_W-1:0]      in_pixel_green = '0;
  logic [CLR_W-1:0]      in_pixel_red   = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_ready      = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  flush          = 1'b0;

  logic                  in_ready;
  logic                  out_valid;
  logic [COL_W-1:0]      out_seg_start_col;
  logic [COL_W-1:0]      out_seg_end_col;
  logic [ROW_W-1:0]      out_seg_row;
  logic [CLR_W-1:0]      out_seg_red;
  logic [CLR_W-1:0]      out_seg_green;
  logic [CLR_W-1:0]      out_seg_blue;
  logic                  out_last;

  int fail_count;
  int words_due;
  int idle_rate  = 0;
  int stall_rate = 0;
  bit hold_req   = 1'b0;

  pixel_run_segmenter_by_color_similarity dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_blue     (in_pixel_blue),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_red      (in_pixel_red),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_seg_start_col (out_seg_start_col),
    .out_seg_end_col   (out_seg_end_col),
    .out_seg_row       (out_seg_row),
    .out_seg_red       (out_seg_red),
    .out_seg_green     (out_seg_green),
    .out_seg_blue      (out_seg_blue),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  prseg_run_checker run_watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_blue        (in_pixel_blue),
    .in_green       (in_pixel_green),
    .in_red         (in_pixel_red),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_start_col  (out_seg_start_col),
    .out_end_col    (out_seg_end_col),
    .out_row        (out_seg_row),
    .out_red        (out_seg_red),
    .out_green      (out_seg_green),
    .out_blue       (out_seg_blue),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .flush          (flush),
    .fail_count     (fail_count),
    .words_due      (words_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] jitter(input logic [7:0] c, input int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [14:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return 15'd0;
      1:       return 15'd25600;
      2:       return 15'($urandom_range(25601, 32767));
      3:       return 15'($urandom_range(1, 12800));
      default: return 15'($urandom_range(12800, 25599));
    endcase
  endfunction

  function automatic logic [12:0] pick_width();
    case ($urandom_range(0, 11))
      0:       return 13'd0;
      1:       return 13'($urandom_range(4096, 8191));
      2:       return 13'($urandom_range(1, 4096));
      default: return 13'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input bit fs);
    if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_blue  <= b;
    in_pixel_green <= g;
    in_pixel_red   <= r;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic quiesce();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(input metric_t metric, input logic [14:0] thr,
                          input logic [12:0] width);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_METRIC;
    cfg_data  <= {13'($urandom), metric};
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_ROW_WIDTH;
    cfg_data  <= {2'($urandom), width};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_scene(input int count, input int spread, input bit new_frame,
                            input bit stray_frames);
    logic [7:0] bb, bg, br;
    bit         fs;
    bb = 8'($urandom);
    bg = 8'($urandom);
    br = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) ? new_frame : (stray_frames && $urandom_range(0, 59) == 0);
      if ($urandom_range(0, 11) == 0) begin
        bb = 8'($urandom);
        bg = 8'($urandom);
        br = 8'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
        push_pixel(8'($urandom), 8'($urandom), 8'($urandom), fs);
      end else begin
        push_pixel(jitter(bb, spread), jitter(bg, spread), jitter(br, spread), fs);
      end
    end
  endtask

  task automatic random_segments(input int total);
    int sent;
    int n;
    int spreads[5];
    sent    = 0;
    spreads = '{0, 3, 12, 40, 128};
    while (sent < total) begin
      n = $urandom_range(20, 120);
      quiesce();
      set_regs(metric_t'($urandom_range(0, 3)), pick_threshold(), pick_width());
      send_scene(n, spreads[$urandom_range(0, 4)], $urandom_range(0, 2) == 0, 1'b1);
      sent += n;
    end
  endtask

  initial begin : stimulus
    int rates[3];
    rates = '{0, 3, 10};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    quiesce();

    set_regs(METRIC_MANHATTAN, 15'd0, 13'd3);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd128, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd7, 8'd7, 8'd7, 1'b0);
    quiesce();

    set_regs(METRIC_COSINE, 15'd25600, 13'd4);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    push_pixel(8'd20, 8'd40, 8'd60, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    quiesce();

    set_regs(METRIC_NONE, 15'd32767, 13'd0);
    push_pixel(8'd1, 8'd2, 8'd3, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    quiesce();

    set_regs(METRIC_MANHATTAN, 15'd25600, 13'd8);
    push_pixel(8'd9, 8'd9, 8'd9, 1'b1);
    push_pixel(8'd9, 8'd9, 8'd9, 1'b0);
    push_pixel(8'd10, 8'd9, 8'd9, 1'b0);
    quiesce();
    set_regs(METRIC_MANHATTAN, 15'd25600, 13'd2);
    push_pixel(8'd9, 8'd9, 8'd9, 1'b0);
    push_pixel(8'd200, 8'd100, 8'd50, 1'b0);

    for (int blk = 0; blk < 6; blk++) begin
      idle_rate  = rates[$urandom_range(0, 2)];
      stall_rate = rates[$urandom_range(0, 2)];
      if (blk == 2) begin
        quiesce();
        set_regs(METRIC_EUCLID, 15'd20480, 13'd4);
        hold_req = 1'b1;
        send_scene(60, 40, 1'b1, 1'b0);
      end
      random_segments(220);
    end

    idle_rate  = 0;
    stall_rate = 0;
    quiesce();
    set_regs(METRIC_MANHATTAN, 15'd24000, 13'd8191);
    send_scene(80, 6, 1'b1, 1'b0);
    quiesce();
    set_regs(METRIC_EUCLID, 15'd20480, 13'd1);
    send_scene(80, 40, 1'b1, 1'b0);

    quiesce();
    flush <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* pixel_run_segmenter_by_color_similarity.f */
design/prseg_pkg.sv
design/prseg_ctrl.sv
design/prseg_dp.sv
design/pixel_run_segmenter_by_color_similarity.sv
tb/prseg_run_checker.sv
tb/tb_top.sv
